>>> rtl/assert_macros.svh
// Assertion macros used by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold at every clock edge outside reset.
`define AST_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define AST_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`endif

>>> rtl/pngse_pkg.sv
// Types, constants and the CRC-32 table of the stored-deflate PNG encoder.
package pngse_pkg;

   localparam logic [12:0] MAX_WIDTH        = 13'd4096;
   localparam logic [12:0] MAX_HEIGHT       = 13'd4096;
   localparam logic [15:0] STORED_BLOCK_MAX = 16'hFFFF;
   localparam logic [16:0] ADLER_MOD        = 17'd65521;

   // register indexes on the configuration port
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ALPHA  = 2'd2;

   // input item kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                          8'd13, 8'd10, 8'd26, 8'd10};

   // IEND length, type and CRC, a fixed tail
   localparam logic [7:0] IEND_CHUNK [12] = '{8'h00, 8'h00, 8'h00, 8'h00,
                                              8'h49, 8'h45, 8'h4E, 8'h44,
                                              8'hAE, 8'h42, 8'h60, 8'h82};

   typedef enum logic [2:0] {
      ST_NEW, ST_HEAD, ST_BH, ST_FILT, ST_DATA, ST_TAIL, ST_ERR
   } st_type;

   // where a stored-block header hands over
   typedef enum logic [1:0] {NX_DONE, NX_FILT, NX_DATA} nx_type;

   typedef struct packed {
      logic       crc_en;
      logic       crc_aux;
      logic       crc_init;
      logic       adler_en;
      logic       adler_init;
      logic [7:0] data;
   } chk_ctl_type;

   typedef struct packed {
      logic [31:0] crc_acc;
      logic [31:0] crc_aux;
      logic [15:0] adler_low;
      logic [15:0] adler_high;
   } chk_sum_type;

   typedef logic [31:0] crc_tab_type [256];

   function automatic crc_tab_type gen_crc_lut();
      crc_tab_type t;
      logic [31:0] c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_tab_type CRC_LUT = gen_crc_lut();

   function automatic logic [31:0] crc_upd(input logic [31:0] c, input logic [7:0] b);
      return CRC_LUT[c[7:0] ^ b] ^ (c >> 8);
   endfunction

endpackage

>>> rtl/pngse_ifs.sv
// Valid/ready channel interfaces of the encoder.
interface pngse_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] pixel_byte;
   modport source (output valid, req_type, pixel_byte, input ready);
   modport sink   (input valid, req_type, pixel_byte, output ready);
endinterface

interface pngse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       image_end;
   logic       status;
   modport source (output valid, out_byte, last_of_run, image_end, status, input ready);
   modport sink   (input valid, out_byte, last_of_run, image_end, status, output ready);
endinterface

>>> rtl/png_stored_deflate_encoder_unit.sv
// Top level: streaming PNG encoder with stored (uncompressed) deflate blocks.
// Input channel req_ch: a start item (req_type 0) or one pixel channel byte
// (req_type 1) in raster order. Output channel rsp_ch: the PNG file, one byte
// per transfer, with last_of_run on the final byte of each input item and
// image_end on the final byte of the file. Image size and alpha come from the
// APB registers and are latched by the start item.
// Throughput: one output byte per cycle while the receiver takes it. A pixel
// item gives its data byte, plus the filter byte at a row start, plus 5 bytes
// of a stored-block header, plus 20 trailer bytes after the last byte. A start item gives 48 bytes.
// The first byte of an item goes into the output register after the item is
// registered, once the output register is free. The item register takes the next
// item in the cycle its last byte goes out, so items flow back to back.
// Reset: synchronous; registers return to 1x1 RGB, no image is active.
// Receiver stall: the output register holds its byte, the sequencer waits,
// and req_ch.ready stays low while the item register holds an item whose
// last byte is not going out.
`include "assert_macros.svh"

module png_stored_deflate_encoder_unit import pngse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pngse_req_if.sink   req_ch,
   pngse_rsp_if.source rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration registers
   logic [12:0] cfg_w_ff, cfg_h_ff;
   logic        cfg_a_ff;

   // item register
   logic        item_v_ff, item_type_ff;
   logic [7:0]  item_byte_ff;

   // sequencer and image state
   st_type      st_ff, st_in, eff_st;
   nx_type      nx_ff, nx_in, eff_nx;
   logic [5:0]  idx_ff, idx_in, tidx;
   logic        phase_ff, phase_in;
   logic [14:0] col_ff, col_in;
   logic [15:0] col_nx;
   logic [15:0] blk_ff, blk_in;
   logic [26:0] raw_ff, raw_in;

   // latched image geometry and size arithmetic
   logic [12:0] lw_ff, lh_ff, w_clamp, h_clamp;
   logic        la_ff;
   logic [14:0] rowlen_ff;
   logic [26:0] rawtot_ff;
   logic [11:0] nblk_ff;
   logic [27:0] idat_ff;
   logic [27:0] ceil_x;
   logic [16:0] ceil_s;

   // output register
   logic        rsp_v_ff, rsp_last_ff, rsp_end_ff, rsp_stat_ff;
   logic [7:0]  rsp_byte_ff;

   logic        emit, req_take;
   logic [7:0]  ob;
   logic        o_last, o_end, o_stat;
   logic        bh_final;
   logic [15:0] bh_len, bh_nlen;
   logic [31:0] aux_fin, acc_fin;
   chk_ctl_type ctl;
   chk_sum_type sum;

   pngse_chk u_chk (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sum   (sum)
   );

   // ---- configuration port ----
   assign pready = 1'b1;
   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:  prdata = {19'd0, cfg_w_ff};
         REG_HEIGHT: prdata = {19'd0, cfg_h_ff};
         REG_ALPHA:  prdata = {31'd0, cfg_a_ff};
         default:    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= 13'd1;
         cfg_h_ff <= 13'd1;
         cfg_a_ff <= 1'b0;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_WIDTH:  cfg_w_ff <= pwdata[12:0];
            REG_HEIGHT: cfg_h_ff <= pwdata[12:0];
            REG_ALPHA:  cfg_a_ff <= pwdata[0];
            default:    ;
         endcase
      end
   end

   // ---- handshakes ----
   assign emit         = item_v_ff && (!rsp_v_ff || rsp_ch.ready);
   assign req_ch.ready = !item_v_ff || (emit && o_last);
   assign req_take     = req_ch.valid && req_ch.ready;

   // ---- block header fields, from the raw bytes still owed ----
   assign bh_final = (raw_ff <= {11'd0, STORED_BLOCK_MAX});
   assign bh_len   = bh_final ? raw_ff[15:0] : STORED_BLOCK_MAX;
   assign bh_nlen  = ~bh_len;
   assign aux_fin  = ~sum.crc_aux;
   assign acc_fin  = ~sum.crc_acc;
   assign tidx     = idx_ff - 6'd8;
   assign col_nx   = {1'b0, col_ff} + 16'd1;

   assign w_clamp = (cfg_w_ff == 13'd0) ? 13'd1 :
                    (cfg_w_ff > MAX_WIDTH) ? MAX_WIDTH : cfg_w_ff;
   assign h_clamp = (cfg_h_ff == 13'd0) ? 13'd1 :
                    (cfg_h_ff > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h_ff;

   // ceil(raw / 65535): split at bit 16, one add and compare for the carry
   assign ceil_x = {1'b0, rawtot_ff} + 28'd65534;
   assign ceil_s = {5'd0, ceil_x[27:16]} + {1'b0, ceil_x[15:0]};

   // ---- sequencer: one output byte per emit ----
   always_comb begin
      // a fresh item picks its first step from the current image state
      eff_st = st_ff;
      eff_nx = nx_ff;
      if (st_ff == ST_NEW) begin
         if (item_type_ff == REQ_START) begin
            eff_st = ST_HEAD;
         end else if (!phase_ff || raw_ff == 27'd0) begin
            eff_st = ST_ERR;
         end else if (col_ff == 15'd0) begin
            if (blk_ff == 16'd0) begin
               eff_st = ST_BH;
               eff_nx = NX_FILT;
            end else begin
               eff_st = ST_FILT;
            end
         end else if (blk_ff == 16'd0) begin
            eff_st = ST_BH;
            eff_nx = NX_DATA;
         end else begin
            eff_st = ST_DATA;
         end
      end

      st_in    = eff_st;
      nx_in    = eff_nx;
      idx_in   = idx_ff + 6'd1;
      phase_in = phase_ff;
      col_in   = col_ff;
      blk_in   = blk_ff;
      raw_in   = raw_ff;
      ob       = 8'd0;
      o_last   = 1'b0;
      o_end    = 1'b0;
      o_stat   = 1'b0;
      ctl      = '0;

      case (eff_st)
         ST_HEAD: begin
            case (idx_ff) inside
               [6'd0:6'd7]:   ob = PNG_SIG[idx_ff[2:0]];
               6'd11:         ob = 8'd13;
               6'd12, 6'd37:  ob = 8'h49;
               6'd13:         ob = 8'h48;
               6'd14, 6'd38:  ob = 8'h44;
               6'd15:         ob = 8'h52;
               6'd18:         ob = {3'd0, lw_ff[12:8]};
               6'd19:         ob = lw_ff[7:0];
               6'd22:         ob = {3'd0, lh_ff[12:8]};
               6'd23:         ob = lh_ff[7:0];
               6'd24:         ob = 8'd8;
               6'd25:         ob = la_ff ? 8'd6 : 8'd2;
               6'd29:         ob = aux_fin[31:24];
               6'd30:         ob = aux_fin[23:16];
               6'd31:         ob = aux_fin[15:8];
               6'd32:         ob = aux_fin[7:0];
               6'd33:         ob = {4'd0, idat_ff[27:24]};
               6'd34:         ob = idat_ff[23:16];
               6'd35:         ob = idat_ff[15:8];
               6'd36:         ob = idat_ff[7:0];
               6'd39:         ob = 8'h41;
               6'd40:         ob = 8'h54;
               6'd41:         ob = 8'h78;
               6'd42:         ob = 8'h01;
               default:       ob = 8'd0;
            endcase
            // IHDR CRC runs on the spare accumulator, IDAT CRC on the main one
            if (idx_ff >= 6'd12 && idx_ff <= 6'd28) begin
               ctl.crc_en   = 1'b1;
               ctl.crc_aux  = 1'b1;
               ctl.crc_init = (idx_ff == 6'd12);
            end
            if (idx_ff >= 6'd37) begin
               ctl.crc_en   = 1'b1;
               ctl.crc_init = (idx_ff == 6'd37);
            end
            if (idx_ff == 6'd0) begin
               ctl.adler_init = 1'b1;
               phase_in       = 1'b1;
               col_in         = 15'd0;
               blk_in         = 16'd0;
            end
            if (idx_ff == 6'd3) begin
               raw_in = rawtot_ff;
            end
            if (idx_ff == 6'd42) begin
               st_in  = ST_BH;
               nx_in  = NX_DONE;
               idx_in = 6'd0;
            end
         end
         ST_BH: begin
            ctl.crc_en = 1'b1;
            case (idx_ff)
               6'd0:    ob = {7'd0, bh_final};
               6'd1:    ob = bh_len[7:0];
               6'd2:    ob = bh_len[15:8];
               6'd3:    ob = bh_nlen[7:0];
               default: ob = bh_nlen[15:8];
            endcase
            if (idx_ff == 6'd4) begin
               blk_in = bh_len;
               idx_in = 6'd0;
               case (eff_nx)
                  NX_FILT: st_in  = ST_FILT;
                  NX_DATA: st_in  = ST_DATA;
                  default: o_last = 1'b1;
               endcase
            end
         end
         ST_FILT: begin
            ctl.crc_en   = 1'b1;
            ctl.adler_en = 1'b1;
            raw_in       = raw_ff - 27'd1;
            blk_in       = blk_ff - 16'd1;
            idx_in       = 6'd0;
            if (blk_ff == 16'd1) begin
               st_in = ST_BH;
               nx_in = NX_DATA;
            end else begin
               st_in = ST_DATA;
            end
         end
         ST_DATA: begin
            ob           = item_byte_ff;
            ctl.crc_en   = 1'b1;
            ctl.adler_en = 1'b1;
            raw_in       = raw_ff - 27'd1;
            blk_in       = blk_ff - 16'd1;
            idx_in       = 6'd0;
            col_in       = (col_nx >= {1'b0, rowlen_ff}) ? 15'd0 : col_nx[14:0];
            if (raw_ff == 27'd1) begin
               st_in = ST_TAIL;
            end else begin
               o_last = 1'b1;
            end
         end
         ST_TAIL: begin
            case (idx_ff) inside
               6'd0:          ob = sum.adler_high[15:8];
               6'd1:          ob = sum.adler_high[7:0];
               6'd2:          ob = sum.adler_low[15:8];
               6'd3:          ob = sum.adler_low[7:0];
               6'd4:          ob = acc_fin[31:24];
               6'd5:          ob = acc_fin[23:16];
               6'd6:          ob = acc_fin[15:8];
               6'd7:          ob = acc_fin[7:0];
               [6'd8:6'd19]:  ob = IEND_CHUNK[tidx[3:0]];
               default:       ob = 8'd0;
            endcase
            ctl.crc_en = (idx_ff <= 6'd3);
            if (idx_ff == 6'd19) begin
               o_last   = 1'b1;
               o_end    = 1'b1;
               phase_in = 1'b0;
            end
         end
         ST_ERR: begin
            o_stat = 1'b1;
            o_last = 1'b1;
         end
         default: ;
      endcase

      ctl.data = ob;
      if (o_last) begin
         st_in  = ST_NEW;
         idx_in = 6'd0;
      end
      if (!emit) begin
         ctl = '0;
      end
   end

   // ---- state registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
         st_ff     <= ST_NEW;
         nx_ff     <= NX_DONE;
         idx_ff    <= 6'd0;
         phase_ff  <= 1'b0;
         col_ff    <= 15'd0;
         blk_ff    <= 16'd0;
         raw_ff    <= 27'd0;
         rsp_v_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            item_v_ff <= 1'b1;
         end else if (emit && o_last) begin
            item_v_ff <= 1'b0;
         end
         if (emit) begin
            st_ff    <= st_in;
            nx_ff    <= nx_in;
            idx_ff   <= idx_in;
            phase_ff <= phase_in;
            col_ff   <= col_in;
            blk_ff   <= blk_in;
            raw_ff   <= raw_in;
            rsp_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_type_ff <= req_ch.req_type;
         item_byte_ff <= req_ch.pixel_byte;
      end
      if (emit) begin
         rsp_byte_ff <= ob;
         rsp_last_ff <= o_last;
         rsp_end_ff  <= o_end;
         rsp_stat_ff <= o_stat;
      end
      // image size arithmetic steps along with the first header bytes
      if (emit && eff_st == ST_HEAD) begin
         case (idx_ff)
            6'd0: begin
               lw_ff <= w_clamp;
               lh_ff <= h_clamp;
               la_ff <= cfg_a_ff;
            end
            6'd1: rowlen_ff <= la_ff ? {lw_ff, 2'b00} : ({2'b00, lw_ff} + {1'b0, lw_ff, 1'b0});
            6'd2: rawtot_ff <= {14'd0, lh_ff} * ({12'd0, rowlen_ff} + 27'd1);
            6'd3: nblk_ff   <= ceil_x[27:16] + {11'd0, (ceil_s >= 17'd65535)};
            6'd4: idat_ff   <= {1'b0, rawtot_ff} + {14'd0, nblk_ff, 2'b00}
                               + {16'd0, nblk_ff} + 28'd6;
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_v_ff;
   assign rsp_ch.out_byte    = rsp_byte_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;
   assign rsp_ch.image_end   = rsp_end_ff;
   assign rsp_ch.status      = rsp_stat_ff;

   // ---- assertions ----
   `AST_PROP(a_end_is_last, clock, reset, rsp_v_ff && rsp_end_ff |-> rsp_last_ff, "image end without last")
   `AST_PROP(a_raw_owed, clock, reset, emit && (eff_st == ST_FILT || eff_st == ST_DATA) |-> raw_ff != 27'd0 && blk_ff != 16'd0, "raw byte with empty block")
   `AST_PROP(a_item_retire, clock, reset, $fell(item_v_ff) |-> $past(emit && o_last), "item dropped before last byte")

endmodule

>>> rtl/pngse_chk.sv
// CRC-32 and Adler-32 accumulators, one byte per cycle while enabled.
module pngse_chk import pngse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  chk_ctl_type ctl,
   output chk_sum_type sum
);

   logic [31:0] acc_ff, aux_ff, acc_in, aux_in, crc_src, crc_new;
   logic [15:0] low_ff, high_ff, low_in, high_in;
   logic [16:0] lo_sum, lo_mod, hi_sum, hi_mod;

   always_comb begin
      crc_src = ctl.crc_init ? 32'hFFFFFFFF : (ctl.crc_aux ? aux_ff : acc_ff);
      crc_new = crc_upd(crc_src, ctl.data);
      acc_in  = (ctl.crc_en && !ctl.crc_aux) ? crc_new : acc_ff;
      aux_in  = (ctl.crc_en && ctl.crc_aux) ? crc_new : aux_ff;

      lo_sum = {1'b0, low_ff} + {9'd0, ctl.data};
      lo_mod = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
      hi_sum = {1'b0, high_ff} + lo_mod;
      hi_mod = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
      if (ctl.adler_init) begin
         low_in  = 16'd1;
         high_in = 16'd0;
      end else if (ctl.adler_en) begin
         low_in  = lo_mod[15:0];
         high_in = hi_mod[15:0];
      end else begin
         low_in  = low_ff;
         high_in = high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 32'hFFFFFFFF;
         aux_ff  <= 32'hFFFFFFFF;
         low_ff  <= 16'd1;
         high_ff <= 16'd0;
      end else begin
         acc_ff  <= acc_in;
         aux_ff  <= aux_in;
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign sum.crc_acc    = acc_ff;
   assign sum.crc_aux    = aux_ff;
   assign sum.adler_low  = low_ff;
   assign sum.adler_high = high_ff;

endmodule

>>> dv/tb_png_stored_deflate_encoder_unit.sv
// Self-checking testbench of the stored-deflate PNG encoder, with a byte-stream scoreboard.
module tb_png_stored_deflate_encoder_unit import pngse_pkg::*; ();

   // one predicted byte of the PNG stream with its flags
   typedef struct {
      logic [7:0] data;
      bit         last;
      bit         fin;
      bit         st;
   } png_byte_type;

   // Predicts the PNG stream from the accepted items and checks each output transfer.
   class png_stream_sb_type;
      logic [12:0] cfg_w = 13'd1, cfg_h = 13'd1;
      bit          cfg_a = 0;
      bit          active = 0;
      logic [31:0] idat_crc = 32'hFFFFFFFF, aux_crc;
      int unsigned adl = 1, adh = 0, col = 0, row_len = 0, blk_left = 0;
      longint unsigned raw_left = 0;
      png_byte_type stream_q [$];
      int          errors = 0, images_done = 0, bytes_checked = 0;

      function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
         c ^= {24'd0, b};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
         return c;
      endfunction

      // sel: 0 no CRC, 1 IDAT CRC, 2 the CRC of IHDR or IEND
      function void put(logic [7:0] b, int sel);
         png_byte_type e;
         if (sel == 1) idat_crc = crc_next(idat_crc, b);
         if (sel == 2) aux_crc = crc_next(aux_crc, b);
         e.data = b; e.last = 0; e.fin = 0; e.st = 0;
         stream_q.push_back(e);
      endfunction

      function void put32(logic [31:0] v, int sel);
         for (int s = 24; s >= 0; s -= 8) put(v[s +: 8], sel);
      endfunction

      function void block_hdr();
         logic [15:0] len, nlen;
         len = (raw_left > 65535) ? 16'hFFFF : 16'(raw_left);
         nlen = ~len;
         put((raw_left <= 65535) ? 8'd1 : 8'd0, 1);
         put(len[7:0], 1); put(len[15:8], 1); put(nlen[7:0], 1); put(nlen[15:8], 1);
         blk_left = 32'(len);
      endfunction

      function void raw_put(logic [7:0] b);
         if (blk_left == 0) block_hdr();
         put(b, 1);
         adl = (adl + b) % 65521;
         adh = (adh + adl) % 65521;
         raw_left--;
         blk_left--;
      endfunction

      function void start_image();
         int unsigned w, h, bpp;
         longint unsigned raw, blocks;
         logic [63:0] idat;
         logic [7:0] sig [8] = '{137, 80, 78, 71, 13, 10, 26, 10};
         w = (cfg_w < 1) ? 1 : (cfg_w > 4096) ? 4096 : cfg_w;
         h = (cfg_h < 1) ? 1 : (cfg_h > 4096) ? 4096 : cfg_h;
         bpp = cfg_a ? 4 : 3;
         foreach (sig[i]) put(sig[i], 0);
         put32(32'd13, 0);
         aux_crc = 32'hFFFFFFFF;
         put("I", 2); put("H", 2); put("D", 2); put("R", 2);
         put32(w, 2); put32(h, 2);
         put(8'd8, 2); put(cfg_a ? 8'd6 : 8'd2, 2);
         put(8'd0, 2); put(8'd0, 2); put(8'd0, 2);
         put32(~aux_crc, 0);
         row_len = w * bpp;
         raw = longint'(h) * (row_len + 1);
         blocks = (raw + 65534) / 65535;
         idat = 2 + 5 * blocks + raw + 4;
         put32(idat[31:0], 0);
         idat_crc = 32'hFFFFFFFF;
         put("I", 1); put("D", 1); put("A", 1); put("T", 1); put(8'h78, 1); put(8'h01, 1);
         raw_left = raw;
         block_hdr();
         adl = 1; adh = 0; col = 0;
         active = 1;
      endfunction

      function void finish_image();
         logic [15:0] lo, hi;
         lo = 16'(adl); hi = 16'(adh);
         put(hi[15:8], 1); put(hi[7:0], 1); put(lo[15:8], 1); put(lo[7:0], 1);
         put32(~idat_crc, 0);
         put32(32'd0, 0);
         aux_crc = 32'hFFFFFFFF;
         put("I", 2); put("E", 2); put("N", 2); put("D", 2);
         put32(~aux_crc, 0);
         stream_q[stream_q.size() - 1].fin = 1;
         active = 0;
         images_done++;
      endfunction

      // accepted input transfer
      function void note_item(bit kind, logic [7:0] b);
         if (kind == REQ_START) begin
            start_image();
         end else if (!active || raw_left == 0) begin
            put(8'd0, 0);
            stream_q[stream_q.size() - 1].st = 1;
         end else begin
            if (col == 0) raw_put(8'd0);
            raw_put(b);
            col++;
            if (col >= row_len) col = 0;
            if (raw_left == 0) finish_image();
         end
         stream_q[stream_q.size() - 1].last = 1;
      endfunction

      // accepted output transfer
      function void check_byte(logic [7:0] b, logic l, logic e, logic s);
         png_byte_type x;
         bytes_checked++;
         if (stream_q.size() == 0) begin
            $display("%0t: unexpected byte %h", $time, b);
            errors++;
            return;
         end
         x = stream_q.pop_front();
         if (b !== x.data) begin
            $display("%0t: out_byte exp %h got %h", $time, x.data, b); errors++;
         end
         if (l !== x.last) begin
            $display("%0t: last_of_run exp %0d got %0d", $time, x.last, l); errors++;
         end
         if (e !== x.fin) begin
            $display("%0t: image_end exp %0d got %0d", $time, x.fin, e); errors++;
         end
         if (s !== x.st) begin
            $display("%0t: status exp %0d got %0d", $time, x.st, s); errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock, reset;
   logic psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   pngse_req_if req_ch ();
   pngse_rsp_if rsp_ch ();

   png_stream_sb_type sb = new();
   bit quiet = 0;        // no idling on either side
   int items_sent = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   png_stored_deflate_encoder_unit i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // result side: checking, receiver stalls and the watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_byte(rsp_ch.out_byte, rsp_ch.last_of_run, rsp_ch.image_end, rsp_ch.status);
         // receiver stalls come in bursts
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d bytes outstanding", $time, sb.stream_q.size());
            $display("tb_png_stored_deflate_encoder_unit: FAIL");
            $finish;
         end
      end
   end

   // one input transfer; valid stays high into the next call when no gap follows
   task automatic send_item(bit kind, logic [7:0] b);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.pixel_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_item(kind, b);
      items_sent++;
   endtask

   // block idle: every byte out, then a margin for the sequencer
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.stream_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_image(logic [12:0] w, logic [12:0] h, bit a);
      drain();
      csr_write(REG_WIDTH, {19'd0, w});
      csr_write(REG_HEIGHT, {19'd0, h});
      csr_write(REG_ALPHA, {31'd0, a});
      sb.cfg_w = w; sb.cfg_h = h; sb.cfg_a = a;
   endtask

   // start an image and push n pixel bytes of random content
   task automatic run_pixels(int n);
      send_item(REQ_START, 8'($urandom));
      for (int i = 0; i < n; i++) send_item(REQ_PIXEL, 8'($urandom));
   endtask

   initial begin
      int npix;
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.req_type = 1'b0; req_ch.pixel_byte = 8'd0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 4'd0; pwdata = 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pixel while idle, default 1x1 RGB image, extremes of bytes
      send_item(REQ_PIXEL, 8'hFF);
      send_item(REQ_START, 8'h00);
      send_item(REQ_PIXEL, 8'h00);
      send_item(REQ_PIXEL, 8'hFF);
      send_item(REQ_PIXEL, 8'hA5);
      send_item(REQ_PIXEL, 8'h5A);           // after the image ends: error status
      // zero size clamps to 1, RGBA
      set_image(13'd0, 13'd0, 1'b1);
      run_pixels(4);
      // oversize clamps to the maximum, several stored blocks; abandoned by a restart
      set_image(13'h1FFF, 13'h1FFF, 1'b0);
      run_pixels(5);
      set_image(13'd2, 13'd2, 1'b0);
      send_item(REQ_START, 8'd0);
      send_item(REQ_PIXEL, 8'h12);
      send_item(REQ_START, 8'd0);            // restart of an active image
      for (int i = 0; i < 12; i++) send_item(REQ_PIXEL, 8'($urandom));

      // random small images
      while (items_sent < 360) begin
         set_image(13'($urandom_range(0, 5)), 13'($urandom_range(0, 4)),
                   1'($urandom_range(0, 1)));
         npix = ((sb.cfg_w < 1) ? 1 : sb.cfg_w) * ((sb.cfg_h < 1) ? 1 : sb.cfg_h)
                * (sb.cfg_a ? 4 : 3);
         if ($urandom_range(0, 7) == 0) npix = $urandom_range(0, npix);
         run_pixels(npix);
         if ($urandom_range(0, 5) == 0) send_item(REQ_PIXEL, 8'($urandom));
         if ($urandom_range(0, 9) == 0) send_item(REQ_START, 8'($urandom));
      end

      // last part without idling: complete RGBA images, each fed back to back
      quiet = 1;
      set_image(13'd4, 13'd3, 1'b1);
      run_pixels(48);
      set_image(13'd3, 13'd1, 1'b1);
      run_pixels(12);

      drain();
      $display("Covered %0d items, %0d stream bytes, %0d complete images,", items_sent,
               sb.bytes_checked, sb.images_done);
      $display("size clamping, restarts, idle pixel errors and a multi-block IDAT header.");
      if (sb.errors == 0 && sb.stream_q.size() == 0) begin
         $display("tb_png_stored_deflate_encoder_unit: PASS");
      end else begin
         $display("tb_png_stored_deflate_encoder_unit: FAIL");
      end
      $finish;
   end

endmodule
